### rtl/core/byte_ring_fifo_unit_macros.svh
// Assertion macros shared by the byte ring FIFO RTL.
`ifndef BYTE_RING_FIFO_UNIT_MACROS_SVH
`define BYTE_RING_FIFO_UNIT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define BRF_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("byte ring FIFO assertion failed");

// Checks that a trigger is followed by a condition at the next clock edge.
`define BRF_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("byte ring FIFO assertion failed");

`endif

### rtl/core/brf_pkg.sv
// Shared constants for the byte ring FIFO.
package brf_pkg;

  localparam int OPC_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 7;
  localparam int LVL_W   = 12;
  localparam int SIZE_W  = 4;
  localparam int LG_CAP  = 12;

  localparam logic [OPC_W-1:0] OPC_WRITE   = 2'd0;
  localparam logic [OPC_W-1:0] OPC_READ    = 2'd1;
  localparam logic [OPC_W-1:0] OPC_DISCARD = 2'd2;

endpackage

### rtl/core/brf_mem.sv
// Byte storage with one write port and one registered read port.
module brf_mem #(
  parameter int ADDR_W = 12
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [brf_pkg::BYTE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [brf_pkg::BYTE_W-1:0] rd_data
);

  logic [brf_pkg::BYTE_W-1:0] mem_r [2**ADDR_W];
  logic [brf_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/byte_ring_fifo_unit.sv
// Top level of the byte ring FIFO with its control sequencer.
//
// The input channel carries one request: an opcode, a byte to store and a
// byte count. A write stores one byte unless the FIFO is full. A read removes
// up to count bytes (capped at MAX_BURST) and returns one result per byte,
// the final one marked last; an empty read returns a single result without a
// byte. A discard drops up to count bytes and returns one result. Every
// result carries the used and free counts after it.
// A write, a discard or an empty read gives its result in the cycle after
// the request is taken. A read passes each byte through the memory read
// register and the result register, one byte per cycle unless the receiver
// stalls; the storage memory's single read port sets that rate. Requests are
// taken one at a time, back to back for writes and discards without stalls.
// The cfg port sets log2 of the ring size and empties the FIFO.
// Synchronous reset empties the FIFO and selects the largest ring size.
// When the receiver stalls, the result register holds its value and the
// block stalls the input channel and the read burst until it drains.
module byte_ring_fifo_unit #(
  parameter int DEPTH     = 4096,
  parameter int MAX_BURST = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [brf_pkg::SIZE_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [brf_pkg::OPC_W-1:0]   in_opcode,
  input  logic [brf_pkg::BYTE_W-1:0]  in_wr_byte,
  input  logic [brf_pkg::CNT_W-1:0]   in_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [brf_pkg::BYTE_W-1:0]  out_rd_byte,
  output logic                        out_byte_valid,
  output logic [brf_pkg::CNT_W-1:0]   out_moved,
  output logic [brf_pkg::LVL_W-1:0]   out_used_count,
  output logic [brf_pkg::LVL_W-1:0]   out_free_count,
  output logic                        out_last
);

`include "byte_ring_fifo_unit_macros.svh"

  localparam int LG_DEPTH = $clog2(DEPTH + 1) - 1;
  localparam int PTR_W    = (LG_DEPTH < brf_pkg::LG_CAP) ? LG_DEPTH : brf_pkg::LG_CAP;
  localparam int CMP_W    = (PTR_W > brf_pkg::CNT_W) ? PTR_W : brf_pkg::CNT_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                       state_r, state_nxt;
  logic [PTR_W-1:0]           mask_r, mask_nxt;
  logic [PTR_W-1:0]           head_r, head_nxt;
  logic [PTR_W-1:0]           tail_r, tail_nxt;
  logic [brf_pkg::CNT_W-1:0]  n_r, n_nxt;
  logic [brf_pkg::CNT_W-1:0]  k_r, k_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [brf_pkg::BYTE_W-1:0] out_rd_byte_r;
  logic                       out_byte_valid_r;
  logic [brf_pkg::CNT_W-1:0]  out_moved_r;
  logic [PTR_W-1:0]           out_used_r;
  logic [PTR_W-1:0]           out_free_r;
  logic                       out_last_r;

  logic                       out_free;
  logic                       in_take;
  logic [brf_pkg::SIZE_W-1:0] cfg_lg;
  logic [PTR_W-1:0]           cfg_mask;
  logic [brf_pkg::CNT_W-1:0]  cnt_cap;
  logic [PTR_W-1:0]           used_cur;
  logic [brf_pkg::CNT_W-1:0]  n_avail;
  logic [PTR_W-1:0]           head_inc;
  logic [PTR_W-1:0]           tail_inc;
  logic [CMP_W-1:0]           tail_sum;
  logic [brf_pkg::CNT_W-1:0]  k_inc;
  logic                       ld;
  logic [brf_pkg::BYTE_W-1:0] ld_byte;
  logic                       ld_valid;
  logic [brf_pkg::CNT_W-1:0]  ld_moved;
  logic                       ld_last;
  logic [PTR_W-1:0]           ld_used;

  logic                       mem_we;
  logic                       mem_re;
  logic [PTR_W-1:0]           mem_raddr;
  logic [brf_pkg::BYTE_W-1:0] mem_rdata;

  brf_mem #(
    .ADDR_W(PTR_W)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(head_r),
    .wr_data(in_wr_byte),
    .rd_en  (mem_re),
    .rd_addr(mem_raddr),
    .rd_data(mem_rdata)
  );

  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_lg = brf_pkg::SIZE_W'(1);
    end else if (int'(cfg_wr_data) > PTR_W) begin
      cfg_lg = brf_pkg::SIZE_W'(PTR_W);
    end else begin
      cfg_lg = cfg_wr_data;
    end
    for (int i = 0; i < PTR_W; i++) begin
      cfg_mask[i] = (i < int'(cfg_lg));
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign in_take  = in_valid && !in_stall;

  assign cnt_cap  = (int'(in_count) > MAX_BURST) ? brf_pkg::CNT_W'(MAX_BURST) : in_count;
  assign used_cur = (head_r - tail_r) & mask_r;
  assign n_avail  = (CMP_W'(used_cur) < CMP_W'(cnt_cap)) ?
                    brf_pkg::CNT_W'(used_cur) : cnt_cap;
  assign head_inc = (head_r + PTR_W'(1)) & mask_r;
  assign tail_inc = (tail_r + PTR_W'(1)) & mask_r;
  assign tail_sum = CMP_W'(tail_r) + CMP_W'(n_avail);
  assign k_inc    = k_r + brf_pkg::CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    mask_nxt      = mask_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = tail_r;
    ld            = 1'b0;
    ld_byte       = '0;
    ld_valid      = 1'b0;
    ld_moved      = '0;
    ld_last       = 1'b1;
    if (cfg_wr_en) begin
      mask_nxt = cfg_mask;
      head_nxt = '0;
      tail_nxt = '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            case (in_opcode)
              brf_pkg::OPC_WRITE: begin
                ld = 1'b1;
                if (head_inc != tail_r) begin
                  mem_we   = 1'b1;
                  head_nxt = head_inc;
                  ld_moved = brf_pkg::CNT_W'(1);
                end
              end
              brf_pkg::OPC_READ: begin
                if (n_avail == '0) begin
                  ld = 1'b1;
                end else begin
                  mem_re    = 1'b1;
                  n_nxt     = n_avail;
                  k_nxt     = '0;
                  state_nxt = ST_READ;
                end
              end
              brf_pkg::OPC_DISCARD: begin
                ld       = 1'b1;
                tail_nxt = tail_sum[PTR_W-1:0] & mask_r;
                ld_moved = n_avail;
              end
              default: begin
                ld = 1'b1;
              end
            endcase
          end
        end
        ST_READ: begin
          if (out_free) begin
            ld       = 1'b1;
            ld_byte  = mem_rdata;
            ld_valid = 1'b1;
            ld_moved = k_inc;
            ld_last  = (k_inc == n_r);
            tail_nxt = tail_inc;
            k_nxt    = k_inc;
            if (k_inc == n_r) begin
              state_nxt = ST_IDLE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = tail_inc;
            end
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
    ld_used = (head_nxt - tail_nxt) & mask_r;
    if (ld) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mask_r      <= '1;
      head_r      <= '0;
      tail_r      <= '0;
      n_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_rd_byte_r    <= ld_byte;
      out_byte_valid_r <= ld_valid;
      out_moved_r      <= ld_moved;
      out_used_r       <= ld_used;
      out_free_r       <= mask_r - ld_used;
      out_last_r       <= ld_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rd_byte    = out_rd_byte_r;
  assign out_byte_valid = out_byte_valid_r;
  assign out_moved      = out_moved_r;
  assign out_used_count = brf_pkg::LVL_W'(out_used_r);
  assign out_free_count = brf_pkg::LVL_W'(out_free_r);
  assign out_last       = out_last_r;

  `BRF_ASSERT_ALWAYS(a_burst_in_range, (state_r != ST_READ) || (k_r < n_r))
  `BRF_ASSERT_ALWAYS(a_ptrs_in_ring, ((head_r & ~mask_r) == '0) && ((tail_r & ~mask_r) == '0))
  `BRF_ASSERT_NEXT(a_last_byte_ends_burst,
                   (state_r == ST_READ) && out_free && !cfg_wr_en && (k_inc == n_r),
                   (state_r == ST_IDLE) && out_valid_r && out_last_r)
  `BRF_ASSERT_NEXT(a_burst_byte_not_last,
                   (state_r == ST_READ) && out_free && !cfg_wr_en && (k_inc != n_r),
                   (state_r == ST_READ) && out_byte_valid_r && !out_last_r)

endmodule
